[rtl/tts_pkg.sv]
// ----------------------------------------------------------------------------
// tts_pkg
// shared types and constants of the tridiagonal solver
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int MAX_ROWS_DEF  = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int ROW_W         = 6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_PIVOT,
        ST_MUL_Q,
        ST_DIV_P_START,
        ST_DIV_P_WAIT,
        ST_DIV_Q_START,
        ST_DIV_Q_WAIT,
        ST_STORE,
        ST_BACK_READ,
        ST_BACK_MUL,
        ST_BACK_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_p;
        logic pivot;
        logic mul_q;
        logic div_p_start;
        logic div_q_start;
        logic store;
        logic back_read;
        logic back_mul;
        logic emit;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic last;
        logic row_zero;
    } t_status;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] mx;
        logic signed [65:0] mn;
        mx = 66'sd2147483647;
        mn = -66'sd2147483648;
        if (v > mx) begin
            sat32 = 32'sh7fffffff;
        end else if (v < mn) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[DATA_W-1:0];
        end
    endfunction

endpackage

[rtl/tts_divider.sv]
// ----------------------------------------------------------------------------
// tts_divider
// radix-2 signed divider, (num << frac) / den truncated toward zero, saturated
// ----------------------------------------------------------------------------
module tts_divider #(
    parameter int FRAC_BITS = tts_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [tts_pkg::DATA_W-1:0] i_num,
    input  logic signed [tts_pkg::DATA_W-1:0] i_den,
    output logic                              o_done,
    output logic                              o_zero_den,
    output logic signed [tts_pkg::DATA_W-1:0] o_quot
);
    import tts_pkg::*;

    localparam int NW  = DATA_W + FRAC_BITS;
    localparam int CW  = $clog2(NW + 1);

    logic [NW-1:0]   r_dividend;
    logic [NW-1:0]   r_quot;
    logic [DATA_W:0] r_rem;
    logic [DATA_W:0] r_den;
    logic            r_neg;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_fin;
    logic            r_done;
    logic            r_zero;
    logic signed [DATA_W-1:0] r_result;

    logic [DATA_W+1:0] n_trial;
    logic [DATA_W:0]   n_shift;
    logic [NW+1:0]     n_signed;

    assign n_shift = {r_rem[DATA_W-1:0], r_dividend[NW-1]};
    assign n_trial = {1'b0, n_shift} - {1'b0, r_den};
    assign n_signed = r_neg ? -{2'b00, r_quot} : {2'b00, r_quot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_zero <= 1'b0;
        end else begin
            r_done <= i_start ? (i_den == '0) : r_fin;
            r_fin  <= !i_start && r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_dividend <= NW'(i_num[DATA_W-1] ? -{{FRAC_BITS{1'b0}}, i_num}
                                                  : {{FRAC_BITS{1'b0}}, i_num}) << FRAC_BITS;
                r_den  <= i_den[DATA_W-1] ? -{i_den[DATA_W-1], i_den} : {1'b0, i_den};
                r_neg  <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
                r_rem  <= '0;
                r_quot <= '0;
                r_cnt  <= CW'(NW);
                r_zero <= (i_den == '0);
                r_busy <= (i_den != '0);
                if (i_den == '0) begin
                    r_result <= (i_num == '0) ? '0 :
                                (i_num[DATA_W-1] ? 32'sh80000000 : 32'sh7fffffff);
                end
            end else if (r_busy) begin
                r_dividend <= r_dividend << 1;
                if (!n_trial[DATA_W+1]) begin
                    r_rem  <= n_trial[DATA_W:0];
                    r_quot <= {r_quot[NW-2:0], 1'b1};
                end else begin
                    r_rem  <= n_shift;
                    r_quot <= {r_quot[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end else if (r_fin) begin
                r_result <= sat32(66'(signed'(n_signed)));
            end
        end
    end

    assign o_done     = r_done;
    assign o_zero_den = r_zero;
    assign o_quot     = r_result;
endmodule

[rtl/tts_datapath.sv]
// ----------------------------------------------------------------------------
// tts_datapath
// sweep arithmetic, factor stores and back substitution
// ----------------------------------------------------------------------------
module tts_datapath #(
    parameter int MAX_ROWS  = tts_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = tts_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tts_pkg::t_cmd                     i_cmd,
    output tts_pkg::t_status                  o_status,
    input  logic signed [tts_pkg::DATA_W-1:0] i_sub_diag,
    input  logic signed [tts_pkg::DATA_W-1:0] i_main_diag,
    input  logic signed [tts_pkg::DATA_W-1:0] i_super_diag,
    input  logic signed [tts_pkg::DATA_W-1:0] i_rhs_value,
    input  logic                              i_last_row,
    output logic [tts_pkg::ROW_W-1:0]         o_row_index,
    output logic signed [tts_pkg::DATA_W-1:0] o_sweep_p,
    output logic signed [tts_pkg::DATA_W-1:0] o_sweep_q,
    output logic signed [tts_pkg::DATA_W-1:0] o_solution,
    output logic                              o_singular,
    output logic                              o_last_result
);
    import tts_pkg::*;

    localparam int AW = $clog2(MAX_ROWS);

    logic signed [DATA_W-1:0] p_mem [MAX_ROWS];
    logic signed [DATA_W-1:0] q_mem [MAX_ROWS];

    logic [AW-1:0]            r_row;
    logic signed [DATA_W-1:0] r_a, r_b, r_c, r_d;
    logic                     r_last;
    logic signed [DATA_W-1:0] r_prev_p, r_prev_q;
    logic                     r_sing;
    logic signed [DATA_W-1:0] r_prod;
    logic signed [DATA_W-1:0] r_pivot;
    logic signed [DATA_W-1:0] r_qnum;
    logic signed [DATA_W-1:0] r_p, r_q;
    logic signed [DATA_W-1:0] r_rd_p, r_rd_q;
    logic signed [DATA_W-1:0] r_x;
    logic [AW-1:0]            r_back;
    logic                     r_first;

    logic signed [DATA_W-1:0] n_mul_a, n_mul_b;
    logic signed [63:0]       n_full;
    logic signed [DATA_W-1:0] n_mres;
    logic                     n_div_start;
    logic signed [DATA_W-1:0] n_div_num;
    logic                     n_div_done;
    logic                     n_div_zero;
    logic signed [DATA_W-1:0] n_div_q;
    logic                     n_last;

    always_comb begin
        if (i_cmd.back_mul) begin
            n_mul_a = r_x;
            n_mul_b = r_rd_p;
        end else if (i_cmd.mul_p) begin
            n_mul_a = r_a;
            n_mul_b = r_prev_p;
        end else begin
            n_mul_a = r_a;
            n_mul_b = r_prev_q;
        end
    end

    assign n_full = n_mul_a * n_mul_b;
    assign n_mres = sat32(66'(n_full >>> FRAC_BITS));

    assign n_div_start = i_cmd.div_p_start | i_cmd.div_q_start;
    assign n_div_num   = i_cmd.div_p_start ? sat32(-66'(r_c)) : r_qnum;

    tts_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_num      (n_div_num),
        .i_den      (r_pivot),
        .o_done     (n_div_done),
        .o_zero_den (n_div_zero),
        .o_quot     (n_div_q)
    );

    assign n_last = i_last_row || (r_row == AW'(MAX_ROWS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_prev_p <= '0;
            r_prev_q <= '0;
            r_sing   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_a    <= (r_row == '0) ? '0 : i_sub_diag;
                r_b    <= i_main_diag;
                r_c    <= n_last ? '0 : i_super_diag;
                r_d    <= i_rhs_value;
                r_last <= n_last;
            end
            if (i_cmd.mul_p) begin
                r_prod <= n_mres;
            end
            if (i_cmd.pivot) begin
                r_pivot <= sat32(66'(r_b) + 66'(r_prod));
                if ((67'(r_b) + 67'(r_prod)) > 67'sd2147483647 ||
                    (67'(r_b) + 67'(r_prod)) < -67'sd2147483648) begin
                    r_sing <= 1'b1;
                end
            end
            if (i_cmd.mul_q) begin
                r_qnum <= sat32(66'(r_d) - 66'(n_mres));
            end
            if (n_div_done) begin
                if (n_div_zero) begin
                    r_sing <= 1'b1;
                end
                r_q <= n_div_q;
                r_p <= r_q;
            end
            if (i_cmd.store) begin
                r_prev_p <= r_p;
                r_prev_q <= r_q;
                r_back   <= r_row;
                r_first  <= 1'b1;
                if (!r_last) begin
                    r_row <= r_row + 1'b1;
                end
            end
            if (i_cmd.back_mul) begin
                r_x     <= r_first ? r_rd_q : sat32(66'(n_mres) + 66'(r_rd_q));
                r_first <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_back <= r_back - 1'b1;
            end
            if (i_cmd.clear) begin
                r_row    <= '0;
                r_prev_p <= '0;
                r_prev_q <= '0;
                r_sing   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            p_mem[r_row] <= r_p;
            q_mem[r_row] <= r_q;
        end
        if (i_cmd.back_read) begin
            r_rd_p <= p_mem[r_back];
            r_rd_q <= q_mem[r_back];
        end
    end

    assign o_status.div_done = n_div_done;
    assign o_status.last     = r_last;
    assign o_status.row_zero = (r_back == '0);

    assign o_row_index   = ROW_W'(r_back);
    assign o_sweep_p     = r_rd_p;
    assign o_sweep_q     = r_rd_q;
    assign o_solution    = r_x;
    assign o_singular    = r_sing;
    assign o_last_result = (r_back == '0);
endmodule

[rtl/tts_controller.sv]
// ----------------------------------------------------------------------------
// tts_controller
// sequencer for the forward sweep and back substitution
// ----------------------------------------------------------------------------
module tts_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  tts_pkg::t_status i_status,
    output tts_pkg::t_cmd    o_cmd,
    output logic             o_busy,
    output logic             o_valid
);
    import tts_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:        if (i_start) n_state = ST_MUL_P;
            ST_MUL_P:       n_state = ST_PIVOT;
            ST_PIVOT:       n_state = ST_MUL_Q;
            ST_MUL_Q:       n_state = ST_DIV_P_START;
            ST_DIV_P_START: n_state = ST_DIV_P_WAIT;
            ST_DIV_P_WAIT:  if (i_status.div_done) n_state = ST_DIV_Q_START;
            ST_DIV_Q_START: n_state = ST_DIV_Q_WAIT;
            ST_DIV_Q_WAIT:  if (i_status.div_done) n_state = ST_STORE;
            ST_STORE:       n_state = i_status.last ? ST_BACK_READ : ST_IDLE;
            ST_BACK_READ:   n_state = ST_BACK_MUL;
            ST_BACK_MUL:    n_state = ST_BACK_EMIT;
            ST_BACK_EMIT:   n_state = i_status.row_zero ? ST_IDLE : ST_BACK_READ;
            default:        n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.load        = (r_state == ST_IDLE) && i_start;
        o_cmd.mul_p       = (r_state == ST_MUL_P);
        o_cmd.pivot       = (r_state == ST_PIVOT);
        o_cmd.mul_q       = (r_state == ST_MUL_Q);
        o_cmd.div_p_start = (r_state == ST_DIV_P_START);
        o_cmd.div_q_start = (r_state == ST_DIV_Q_START);
        o_cmd.store       = (r_state == ST_STORE);
        o_cmd.back_read   = (r_state == ST_BACK_READ);
        o_cmd.back_mul    = (r_state == ST_BACK_MUL);
        o_cmd.emit        = (r_state == ST_BACK_EMIT);
        o_cmd.clear       = (r_state == ST_BACK_EMIT) && i_status.row_zero;
        o_busy            = (r_state != ST_IDLE);
        o_valid           = (r_state == ST_BACK_EMIT);
    end

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_MUL_P)) else $error("load not followed by sweep");
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy) else $error("result while idle");
    a_div_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_p_start |=> (r_state == ST_DIV_P_WAIT)) else $error("divider order");
endmodule

[rtl/tridiagonal_thomas_solver.sv]
// ----------------------------------------------------------------------------
// tridiagonal_thomas_solver
// fixed-point tridiagonal solver, forward sweep and back substitution
// ----------------------------------------------------------------------------
// One row is taken per start while busy is low. Each row needs two
// multiplies and two divisions on one radix-2 divider of DATA_W+FRAC_BITS
// steps (Q16.16 by default); a division by a zero pivot skips the steps.
// On the last row, results follow, each row passing through the read,
// multiply and emit states, highest row first, each shown for one cycle
// under o_valid; the receiver cannot stall them.
module tridiagonal_thomas_solver #(
    parameter int MAX_ROWS  = tts_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = tts_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [tts_pkg::DATA_W-1:0] i_sub_diag,
    input  logic signed [tts_pkg::DATA_W-1:0] i_main_diag,
    input  logic signed [tts_pkg::DATA_W-1:0] i_super_diag,
    input  logic signed [tts_pkg::DATA_W-1:0] i_rhs_value,
    input  logic                              i_last_row,
    output logic                              o_valid,
    output logic [tts_pkg::ROW_W-1:0]         o_row_index,
    output logic signed [tts_pkg::DATA_W-1:0] o_sweep_p,
    output logic signed [tts_pkg::DATA_W-1:0] o_sweep_q,
    output logic signed [tts_pkg::DATA_W-1:0] o_solution,
    output logic                              o_singular,
    output logic                              o_last_result
);
    import tts_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    tts_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    tts_datapath #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_sub_diag    (i_sub_diag),
        .i_main_diag   (i_main_diag),
        .i_super_diag  (i_super_diag),
        .i_rhs_value   (i_rhs_value),
        .i_last_row    (i_last_row),
        .o_row_index   (o_row_index),
        .o_sweep_p     (o_sweep_p),
        .o_sweep_q     (o_sweep_q),
        .o_solution    (o_solution),
        .o_singular    (o_singular),
        .o_last_result (o_last_result)
    );
endmodule
